// ----- rtl/core/vat_pkg.sv -----
// vat_pkg: shared constants, register codes and types of the vertex transform
// used by the interfaces, the position and normal pipelines and the top level
// depends on nothing
package vat_pkg;

  localparam int COORD_BITS_DEF  = 32;
  localparam int NORMAL_BITS_DEF = 16;

  localparam int COEF_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int NUM_MREGS  = 6;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TNORM    = 3'd6;

  // identity matrix at reset
  localparam logic [CFG_DATA_W-1:0] ROW0_C01_RST = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] ROW1_C01_RST = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW2_C23_RST = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] ZERO_RST     = 64'h0;

  // normal length path
  localparam int MAG_W      = 30;
  localparam int NORM_W     = 64;
  localparam int SQ_W       = 2 * MAG_W + 2;
  localparam int LEN_W      = MAG_W + 1;
  localparam int REM_W      = LEN_W + 2;
  localparam int SQRT_STEPS = SQ_W / 2;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [3:0] coef_row_t;
  typedef coef_row_t [2:0] coef_mat_t;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

// ----- rtl/core/vat_if.sv -----
// vat_if: request channels of the vertex transform (vertex in, result out, config)
// depends on vat_pkg
interface vat_in_if import vat_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int NORMAL_BITS = NORMAL_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  pos_x;
  logic signed [COORD_BITS-1:0]  pos_y;
  logic signed [COORD_BITS-1:0]  pos_z;
  logic signed [NORMAL_BITS-1:0] nrm_x;
  logic signed [NORMAL_BITS-1:0] nrm_y;
  logic signed [NORMAL_BITS-1:0] nrm_z;
  logic                          in_last;

  modport source (output valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, in_last,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, in_last,
                  output ready);
endinterface

interface vat_out_if import vat_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int NORMAL_BITS = NORMAL_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  out_pos_x;
  logic signed [COORD_BITS-1:0]  out_pos_y;
  logic signed [COORD_BITS-1:0]  out_pos_z;
  logic signed [NORMAL_BITS-1:0] out_nrm_x;
  logic signed [NORMAL_BITS-1:0] out_nrm_y;
  logic signed [NORMAL_BITS-1:0] out_nrm_z;
  logic                          normal_degenerate;
  logic                          out_last;

  modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                  out_nrm_z, normal_degenerate, out_last, input ready);
  modport sink   (input valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                  out_nrm_z, normal_degenerate, out_last, output ready);
endinterface

interface vat_cfg_if import vat_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/vat_pos.sv -----
// vat_pos: five-stage position transform, 3x4 matrix times (x, y, z, 1),
// rounded to Q16.16 and saturated; carries a side word alongside
// depends on vat_pkg
module vat_pos import vat_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SIDE_W     = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pipe_ctl_t                    ctl,
  input  coef_mat_t                    coef,
  input  logic [2:0][COORD_BITS-1:0]   pos_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         vld_o,
  output logic [2:0][COORD_BITS-1:0]   pos_o,
  output logic [SIDE_W-1:0]            side_o
);

  localparam int PH_W = COORD_BITS - FRAC_BITS + 1;
  localparam int LP_W = COEF_W + FRAC_BITS + 1;
  localparam int HP_W = COEF_W + PH_W;
  localparam int T_W  = COEF_W + COORD_BITS + 2;
  localparam int SPAN = (COORD_BITS > 2 * FRAC_BITS) ? COORD_BITS : 2 * FRAC_BITS;
  localparam int A_W  = COEF_W + SPAN + 4;
  localparam int R_W  = A_W - FRAC_BITS;
  localparam int NST  = 5;
  localparam logic signed [A_W-1:0] HALF = A_W'(1) << (FRAC_BITS - 1);

  logic signed [PH_W-1:0] ph [3];
  logic signed [LP_W-1:0] lp_r [3][3];
  logic signed [HP_W-1:0] hp_r [3][3];
  logic signed [T_W-1:0]  term_r [3][3];
  logic signed [A_W-1:0]  pa_r [3];
  logic signed [A_W-1:0]  pb_r [3];
  logic signed [R_W-1:0]  rnd_r [3];
  logic [2:0][COORD_BITS-1:0] sat_r;
  logic [2:0][COORD_BITS-1:0] sat_nxt;
  logic [NST-1:0]         vld_r;
  logic [SIDE_W-1:0]      side_r [NST];

  // split each coordinate into a signed upper part and a 16-bit fraction
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ph[k] = PH_W'($signed(pos_i[k]) >>> FRAC_BITS);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if ((&rnd_r[i][R_W-1:COORD_BITS-1]) || !(|rnd_r[i][R_W-1:COORD_BITS-1])) begin
        sat_nxt[i] = rnd_r[i][COORD_BITS-1:0];
      end else if (rnd_r[i][R_W-1]) begin
        sat_nxt[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
        sat_nxt[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.en) begin
      vld_r <= {vld_r[NST-2:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      side_r[0] <= side_i;
      for (int s = 1; s < NST; s++) begin
        side_r[s] <= side_r[s-1];
      end
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          lp_r[i][k] <= $signed(coef[i][k]) * $signed({1'b0, pos_i[k][FRAC_BITS-1:0]});
          hp_r[i][k] <= $signed(coef[i][k]) * ph[k];
          term_r[i][k] <= (T_W'(hp_r[i][k]) <<< FRAC_BITS) + T_W'(lp_r[i][k]);
        end
        pa_r[i]  <= A_W'(term_r[i][0]) + A_W'(term_r[i][1]);
        pb_r[i]  <= A_W'(term_r[i][2]) + (A_W'($signed(coef[i][3])) <<< FRAC_BITS)
                    + HALF;
        rnd_r[i] <= R_W'((pa_r[i] + pb_r[i]) >>> FRAC_BITS);
      end
      sat_r <= sat_nxt;
    end
  end

  assign vld_o  = vld_r[NST-1];
  assign pos_o  = sat_r;
  assign side_o = side_r[NST-1];

endmodule

// ----- rtl/core/vat_nrm.sv -----
// vat_nrm: normal transform pipeline, 3x3 product, normalizing shift,
// bit-per-stage square root and division to a unit vector; carries a side word
// depends on vat_pkg
module vat_nrm import vat_pkg::*; #(
  parameter int NORMAL_BITS = NORMAL_BITS_DEF,
  parameter int SIDE_W      = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pipe_ctl_t                     ctl,
  input  coef_mat_t                     coef,
  input  logic                          tnorm_i,
  input  logic [2:0][NORMAL_BITS-1:0]   nrm_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          vld_o,
  output logic [2:0][NORMAL_BITS-1:0]   nrm_o,
  output logic                          degen_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam int PR_W  = COEF_W + NORMAL_BITS;
  localparam int V_W   = PR_W + 2;
  localparam int QB    = NORMAL_BITS - 1;
  localparam int DN_W  = MAG_W + NORMAL_BITS;
  localparam int DW    = DN_W + 1;
  localparam int DV_W  = LEN_W + 1;
  localparam int SQ0   = 8;
  localparam int DV0   = SQ0 + SQRT_STEPS;
  localparam int NST   = DV0 + QB + 1;

  typedef struct packed {
    logic                        tnorm;
    logic [2:0]                  neg;
    logic                        degen;
    logic [2:0][NORMAL_BITS-1:0] raw;
    logic [SIDE_W-1:0]           side;
  } meta_t;

  logic [NST-1:0]          vld_r;
  meta_t                   meta_r [NST];
  meta_t                   meta_in;
  meta_t                   meta2_nxt;
  meta_t                   meta3_nxt;

  logic signed [PR_W-1:0]  prod_r [3][3];
  logic signed [V_W-1:0]   v_r [3];
  logic [V_W-1:0]          mag_r [3];
  logic [2:0]              neg_nxt;
  logic [NORM_W-1:0]       mx_nxt;
  logic [NORM_W-1:0]       mx_r;
  logic [NORM_W-1:0]       mg64_r [3];
  logic [NORM_W-1:0]       mxa_nxt;
  logic [NORM_W-1:0]       mga_nxt [3];
  logic [NORM_W-1:0]       mxa_r;
  logic [NORM_W-1:0]       mga_r [3];
  logic [NORM_W-1:0]       mgb_nxt [3];
  logic [2:0][MAG_W-1:0]   mg30_r;
  logic [2:0][MAG_W-1:0]   mgs_r;
  logic [2:0][MAG_W-1:0]   mgt_r;
  logic [2*MAG_W-1:0]      sqr_r [3];
  logic [SQ_W-1:0]         sum_r;

  logic [SQ_W-1:0]         rad_r [SQRT_STEPS];
  logic [REM_W-1:0]        rem_r [SQRT_STEPS];
  logic [LEN_W-1:0]        root_r [SQRT_STEPS];
  logic [2:0][MAG_W-1:0]   sq_mag_r [SQRT_STEPS];

  logic [DV_W-1:0]         dvs_r [QB];
  logic [2:0][DW-1:0]      drem_r [QB];
  logic [2:0][QB-1:0]      quo_r [QB];

  logic [2:0][NORMAL_BITS-1:0] nrm_nxt;
  logic [2:0][NORMAL_BITS-1:0] nrm_r;
  logic                        deg_r;

  always_comb begin
    meta_in.tnorm = tnorm_i;
    meta_in.neg   = '0;
    meta_in.degen = 1'b0;
    meta_in.raw   = nrm_i;
    meta_in.side  = side_i;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_nxt[i] = v_r[i][V_W-1];
    end
    mx_nxt = NORM_W'(mag_r[0]);
    if (NORM_W'(mag_r[1]) > mx_nxt) mx_nxt = NORM_W'(mag_r[1]);
    if (NORM_W'(mag_r[2]) > mx_nxt) mx_nxt = NORM_W'(mag_r[2]);
  end

  // signs join the side data one stage after the sums, the zero flag one after that
  always_comb begin
    meta2_nxt       = meta_r[1];
    meta2_nxt.neg   = neg_nxt;
    meta3_nxt       = meta_r[2];
    meta3_nxt.degen = (mx_nxt == '0);
  end

  // leading-zero normalization of the largest magnitude, coarse steps first
  always_comb begin
    mxa_nxt = mx_r;
    for (int k = 0; k < 3; k++) begin
      mga_nxt[k] = mg64_r[k];
    end
    for (int t = 0; t < 3; t++) begin
      if ((mxa_nxt >> (NORM_W - ((NORM_W / 2) >> t))) == '0) begin
        mxa_nxt = mxa_nxt << ((NORM_W / 2) >> t);
        for (int k = 0; k < 3; k++) begin
          mga_nxt[k] = mga_nxt[k] << ((NORM_W / 2) >> t);
        end
      end
    end
  end

  always_comb begin
    logic [NORM_W-1:0] w;
    w = mxa_r;
    for (int k = 0; k < 3; k++) begin
      mgb_nxt[k] = mga_r[k];
    end
    for (int t = 0; t < 3; t++) begin
      if ((w >> (NORM_W - ((NORM_W / 16) >> t))) == '0) begin
        w = w << ((NORM_W / 16) >> t);
        for (int k = 0; k < 3; k++) begin
          mgb_nxt[k] = mgb_nxt[k] << ((NORM_W / 16) >> t);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.en) begin
      vld_r <= {vld_r[NST-2:0], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      meta_r[0] <= meta_in;
      for (int s = 1; s < NST; s++) begin
        if (s == 2) begin
          meta_r[s] <= meta2_nxt;
        end else if (s == 3) begin
          meta_r[s] <= meta3_nxt;
        end else begin
          meta_r[s] <= meta_r[s-1];
        end
      end

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= $signed(coef[i][j]) * $signed(nrm_i[j]);
        end
        v_r[i]    <= V_W'(prod_r[i][0]) + V_W'(prod_r[i][1]) + V_W'(prod_r[i][2]);
        mag_r[i]  <= v_r[i][V_W-1] ? V_W'(-v_r[i]) : V_W'(v_r[i]);
        mg64_r[i] <= NORM_W'(mag_r[i]);
        mga_r[i]  <= mga_nxt[i];
        mg30_r[i] <= mgb_nxt[i][NORM_W-1 -: MAG_W];
        sqr_r[i]  <= mg30_r[i] * mg30_r[i];
      end
      mx_r  <= mx_nxt;
      mxa_r <= mxa_nxt;
      mgs_r <= mg30_r;
      mgt_r <= mgs_r;
      sum_r <= SQ_W'(sqr_r[0]) + SQ_W'(sqr_r[1]) + SQ_W'(sqr_r[2]);
      nrm_r <= nrm_nxt;
      deg_r <= meta_r[NST-2].tnorm & meta_r[NST-2].degen;
    end
  end

  // integer square root, one root bit per stage
  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    logic [SQ_W-1:0]       rad_in;
    logic [REM_W-1:0]      rem_in;
    logic [LEN_W-1:0]      root_in;
    logic [2:0][MAG_W-1:0] mag_in;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;

    if (s == 0) begin : g_first
      assign rad_in  = sum_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign mag_in  = mgt_r;
    end else begin : g_next
      assign rad_in  = rad_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign mag_in  = sq_mag_r[s-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[SQ_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rad_r[s]    <= rad_in << 2;
        sq_mag_r[s] <= mag_in;
        if (rem_sh >= trial) begin
          rem_r[s]  <= rem_sh - trial;
          root_r[s] <= {root_in[LEN_W-2:0], 1'b1};
        end else begin
          rem_r[s]  <= rem_sh;
          root_r[s] <= {root_in[LEN_W-2:0], 1'b0};
        end
      end
    end
  end

  // round-half-away division (mag * 2^(n-1) + len) / (2 len), one quotient bit per stage
  for (genvar d = 0; d < QB; d++) begin : g_div
    logic [DV_W-1:0]    dvs_in;
    logic [2:0][DW-1:0] rem_in;
    logic [2:0][QB-1:0] quo_in;
    logic [DW-1:0]      shifted;

    if (d == 0) begin : g_first
      assign dvs_in = {root_r[SQRT_STEPS-1], 1'b0};
      assign quo_in = '0;
      for (genvar k = 0; k < 3; k++) begin : g_num
        assign rem_in[k] = (DW'(sq_mag_r[SQRT_STEPS-1][k]) << (NORMAL_BITS - 1))
                           + DW'(root_r[SQRT_STEPS-1]);
      end
    end else begin : g_next
      assign dvs_in = dvs_r[d-1];
      assign rem_in = drem_r[d-1];
      assign quo_in = quo_r[d-1];
    end

    assign shifted = DW'(dvs_in) << (QB - 1 - d);

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        dvs_r[d] <= dvs_in;
        for (int k = 0; k < 3; k++) begin
          if (rem_in[k] >= shifted) begin
            drem_r[d][k] <= rem_in[k] - shifted;
            quo_r[d][k]  <= {quo_in[k][QB-2:0], 1'b1};
          end else begin
            drem_r[d][k] <= rem_in[k];
            quo_r[d][k]  <= {quo_in[k][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!meta_r[NST-2].tnorm) begin
        nrm_nxt[k] = meta_r[NST-2].raw[k];
      end else if (meta_r[NST-2].degen) begin
        nrm_nxt[k] = '0;
      end else if (meta_r[NST-2].neg[k]) begin
        nrm_nxt[k] = -NORMAL_BITS'(quo_r[QB-1][k]);
      end else begin
        nrm_nxt[k] = NORMAL_BITS'(quo_r[QB-1][k]);
      end
    end
  end

  assign vld_o   = vld_r[NST-1];
  assign nrm_o   = nrm_r;
  assign degen_o = deg_r;
  assign side_o  = meta_r[NST-1].side;

endmodule

// ----- rtl/core/vertex_affine_transform.sv -----
// vertex_affine_transform: top level, config registers, stall control and
// the position pipeline followed by the normal pipeline
// depends on vat_pkg, vat_if, vat_pos, vat_nrm
//
//   channel  | dir | handshake      | payload
//   in_s     | in  | valid / ready  | pos_x/y/z, nrm_x/y/z, in_last
//   out_s    | out | valid / ready  | out_pos_x/y/z, out_nrm_x/y/z, normal_degenerate, out_last
//   cfg_s    | in  | valid / ready  | index, data (ready always high)
//
// one vertex per cycle sustained while no finished result waits at the output
// the normal pipeline is mostly the square root (one root bit per stage) and the divider
// (one quotient bit per stage), behind the five position stages
// rst_n is synchronous: clears valid bits and loads the identity matrix
// when the output waits, all stages hold together and in_s.ready drops
module vertex_affine_transform import vat_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int NORMAL_BITS = NORMAL_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  vat_in_if.sink           in_s,
  vat_out_if.source        out_s,
  vat_cfg_if.sink          cfg_s
);

  localparam int PS_W = 3 * NORMAL_BITS + 1;
  localparam int NS_W = 3 * COORD_BITS + 1;

  logic [CFG_DATA_W-1:0] mreg_r [NUM_MREGS];
  logic                  tnorm_r;
  coef_mat_t             coef;
  pipe_ctl_t             ctl;
  pipe_ctl_t             nrm_ctl;

  logic [2:0][COORD_BITS-1:0]  pos_in;
  logic [2:0][COORD_BITS-1:0]  pos_res;
  logic [PS_W-1:0]             pos_side_i;
  logic [PS_W-1:0]             pos_side_o;
  logic                        pos_vld;
  logic [NS_W-1:0]             nrm_side_o;
  logic [2:0][NORMAL_BITS-1:0] nrm_res;
  logic [2:0][COORD_BITS-1:0]  pos_out;
  logic                        nrm_vld;
  logic                        nrm_deg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mreg_r[0] <= ROW0_C01_RST;
      mreg_r[1] <= ZERO_RST;
      mreg_r[2] <= ROW1_C01_RST;
      mreg_r[3] <= ZERO_RST;
      mreg_r[4] <= ZERO_RST;
      mreg_r[5] <= ROW2_C23_RST;
      tnorm_r   <= 1'b1;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        REG_ROW0_C01: mreg_r[0] <= cfg_s.data;
        REG_ROW0_C23: mreg_r[1] <= cfg_s.data;
        REG_ROW1_C01: mreg_r[2] <= cfg_s.data;
        REG_ROW1_C23: mreg_r[3] <= cfg_s.data;
        REG_ROW2_C01: mreg_r[4] <= cfg_s.data;
        REG_ROW2_C23: mreg_r[5] <= cfg_s.data;
        REG_TNORM:    tnorm_r   <= cfg_s.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_s.ready = 1'b1;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = (c % 2 == 1) ? mreg_r[r * 2 + c / 2][CFG_DATA_W-1:COEF_W]
                                  : mreg_r[r * 2 + c / 2][COEF_W-1:0];
      end
    end
  end

  // whole pipeline advances unless a finished result waits
  assign ctl.en  = !nrm_vld || out_s.ready;
  assign ctl.vld = in_s.valid;
  assign in_s.ready = ctl.en;

  assign nrm_ctl.en  = ctl.en;
  assign nrm_ctl.vld = pos_vld;

  assign pos_in     = {in_s.pos_z, in_s.pos_y, in_s.pos_x};
  assign pos_side_i = {in_s.nrm_z, in_s.nrm_y, in_s.nrm_x, in_s.in_last};

  vat_pos #(
    .COORD_BITS (COORD_BITS),
    .SIDE_W     (PS_W)
  ) u_pos (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .coef   (coef),
    .pos_i  (pos_in),
    .side_i (pos_side_i),
    .vld_o  (pos_vld),
    .pos_o  (pos_res),
    .side_o (pos_side_o)
  );

  vat_nrm #(
    .NORMAL_BITS (NORMAL_BITS),
    .SIDE_W      (NS_W)
  ) u_nrm (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (nrm_ctl),
    .coef    (coef),
    .tnorm_i (tnorm_r),
    .nrm_i   (pos_side_o[PS_W-1:1]),
    .side_i  ({pos_res, pos_side_o[0]}),
    .vld_o   (nrm_vld),
    .nrm_o   (nrm_res),
    .degen_o (nrm_deg),
    .side_o  (nrm_side_o)
  );

  assign pos_out = nrm_side_o[NS_W-1:1];

  assign out_s.valid             = nrm_vld;
  assign out_s.out_pos_x         = pos_out[0];
  assign out_s.out_pos_y         = pos_out[1];
  assign out_s.out_pos_z         = pos_out[2];
  assign out_s.out_nrm_x         = nrm_res[0];
  assign out_s.out_nrm_y         = nrm_res[1];
  assign out_s.out_nrm_z         = nrm_res[2];
  assign out_s.normal_degenerate = nrm_deg;
  assign out_s.out_last          = nrm_side_o[0];

endmodule

// ----- rtl/core/vat_checker.sv -----
// vat_checker: port-level assertions of the vertex transform, bound to the top
// depends on vat_pkg, vertex_affine_transform
module vat_checker import vat_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int NORMAL_BITS = NORMAL_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         cfg_ready,
  input logic signed [COORD_BITS-1:0] out_pos_x,
  input logic signed [NORMAL_BITS-1:0] out_nrm_x,
  input logic signed [NORMAL_BITS-1:0] out_nrm_y,
  input logic signed [NORMAL_BITS-1:0] out_nrm_z,
  input logic                         normal_degenerate
);

  // a waiting result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_nrm_x))
    else $error("result changed while stalled");

  // an empty output stage never blocks new requests
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && normal_degenerate |-> out_nrm_x == '0 && out_nrm_y == '0 && out_nrm_z == '0)
    else $error("degenerate normal not zero");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind vertex_affine_transform vat_checker #(
  .COORD_BITS  (COORD_BITS),
  .NORMAL_BITS (NORMAL_BITS)
) u_vat_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_s.ready),
  .out_valid         (out_s.valid),
  .out_ready         (out_s.ready),
  .cfg_ready         (cfg_s.ready),
  .out_pos_x         (out_s.out_pos_x),
  .out_nrm_x         (out_s.out_nrm_x),
  .out_nrm_y         (out_s.out_nrm_y),
  .out_nrm_z         (out_s.out_nrm_z),
  .normal_degenerate (out_s.normal_degenerate)
);

// ----- sim/vat_tb_if.sv -----
// testbench copy of nothing: the rtl interfaces are reused directly
// this file holds one shared testbench constant, the simulated latency
// depends on vat_pkg
package vat_tb_pkg;
  import vat_pkg::*;
  localparam int SIM_LATENCY = NORMAL_BITS_DEF + 44;
endpackage

// ----- sim/vertex_affine_transform_tb.sv -----
// testbench of vertex_affine_transform: drives vertices with random stalls,
// predicts every result from the matrix in use and compares field by field
// depends on vat_pkg, vat_if, vat_tb_pkg and the rtl of the block
module vertex_affine_transform_tb;
  import vat_pkg::*;
  import vat_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic degen;
    logic last;
  } vertex_res_t;

  int errors = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  class vertex_scoreboard;
    logic [63:0] mat_regs [6];
    bit          tnorm;
    vertex_res_t pending [$];
    int          checked;

    function void reset_regs();
      mat_regs[0] = ROW0_C01_RST; mat_regs[1] = ZERO_RST;
      mat_regs[2] = ROW1_C01_RST; mat_regs[3] = ZERO_RST;
      mat_regs[4] = ZERO_RST;     mat_regs[5] = ROW2_C23_RST;
      tnorm = 1;
      checked = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
      if (idx == REG_TNORM) tnorm = d[0];
      else if (idx < REG_TNORM) mat_regs[idx] = d;
    endfunction

    function longint coef(input int r, input int c);
      logic [63:0] w;
      logic signed [31:0] h;
      w = mat_regs[r * 2 + c / 2];
      h = (c % 2) ? w[63:32] : w[31:0];
      return longint'(h);
    endfunction

    function logic signed [31:0] row_pos(input int r, input longint p [3]);
      logic signed [127:0] acc;
      acc = 0;
      for (int k = 0; k < 3; k++) acc += 128'(signed'(coef(r, k))) * 128'(signed'(p[k]));
      acc += 128'(signed'(coef(r, 3))) <<< 16;
      acc = (acc + 128'sd32768) >>> 16;
      if (acc > 128'sd2147483647) return 32'sh7fffffff;
      if (acc < -128'sd2147483648) return 32'sh80000000;
      return acc[31:0];
    endfunction

    function longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function void note_vertex(input logic signed [31:0] px, py, pz,
                              input logic signed [15:0] nx, ny, nz, input logic last);
      vertex_res_t e;
      longint p [3];
      longint n [3];
      longint v;
      longint unsigned mag [3];
      longint unsigned mx, sq, len, q;
      bit neg [3];
      p[0] = px; p[1] = py; p[2] = pz;
      n[0] = nx; n[1] = ny; n[2] = nz;
      e.px = row_pos(0, p); e.py = row_pos(1, p); e.pz = row_pos(2, p);
      e.degen = 0; e.last = last;
      e.nx = nx; e.ny = ny; e.nz = nz;
      if (tnorm) begin
        mx = 0;
        for (int i = 0; i < 3; i++) begin
          v = 0;
          for (int j = 0; j < 3; j++) v += coef(i, j) * n[j];
          neg[i] = v < 0;
          mag[i] = neg[i] ? -v : v;
          if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) begin
          e.nx = 0; e.ny = 0; e.nz = 0; e.degen = 1;
        end else begin
          while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
          end
          while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
          end
          sq = 0;
          for (int i = 0; i < 3; i++) sq += mag[i] * mag[i];
          len = int_sqrt(sq);
          for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 15) + len) / (2 * len);
            n[i] = neg[i] ? -longint'(q) : longint'(q);
          end
          e.nx = n[0][15:0]; e.ny = n[1][15:0]; e.nz = n[2][15:0];
        end
      end
      pending.push_back(e);
    endfunction

    task check_result(input vertex_res_t got);
      vertex_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, count", checked, -1);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.px !== e.px) report_mismatch("out_pos_x", got.px, e.px);
      if (got.py !== e.py) report_mismatch("out_pos_y", got.py, e.py);
      if (got.pz !== e.pz) report_mismatch("out_pos_z", got.pz, e.pz);
      if (got.nx !== e.nx) report_mismatch("out_nrm_x", got.nx, e.nx);
      if (got.ny !== e.ny) report_mismatch("out_nrm_y", got.ny, e.ny);
      if (got.nz !== e.nz) report_mismatch("out_nrm_z", got.nz, e.nz);
      if (got.degen !== e.degen) report_mismatch("normal_degenerate", got.degen, e.degen);
      if (got.last !== e.last) report_mismatch("out_last", got.last, e.last);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   sent = 0;

  vat_in_if  vin ();
  vat_out_if vout ();
  vat_cfg_if vcfg ();

  vertex_affine_transform i_dut (
    .clk(clk), .rst_n(rst_n), .in_s(vin.sink), .out_s(vout.source), .cfg_s(vcfg.sink)
  );

  vertex_scoreboard vsb = new();

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #20_000_000;
    $display("vertex_affine_transform verification failed");
    $finish;
  end

  // receiver: random ready, compare at rising edge
  always @(negedge clk) vout.ready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk) begin
    vertex_res_t r;
    if (rst_n && vout.valid && vout.ready) begin
      r.px = vout.out_pos_x; r.py = vout.out_pos_y; r.pz = vout.out_pos_z;
      r.nx = vout.out_nrm_x; r.ny = vout.out_nrm_y; r.nz = vout.out_nrm_z;
      r.degen = vout.normal_degenerate; r.last = vout.out_last;
      vsb.check_result(r);
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
    vcfg.valid <= 1;
    vcfg.index <= idx;
    vcfg.data  <= d;
    do @(posedge clk); while (!vcfg.ready);
    vsb.write_reg(idx, d);
    @(negedge clk);
    vcfg.valid <= 0;
    @(negedge clk);
  endtask

  // valid stays high across back-to-back requests and drops only while idling or draining
  task automatic send_vertex(input logic signed [31:0] px, py, pz,
                             input logic signed [15:0] nx, ny, nz, input logic last);
    if ($urandom_range(99) < src_idle_pct) begin
      vin.valid <= 0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    vin.valid <= 1;
    vin.pos_x <= px; vin.pos_y <= py; vin.pos_z <= pz;
    vin.nrm_x <= nx; vin.nrm_y <= ny; vin.nrm_z <= nz;
    vin.in_last <= last;
    do @(posedge clk); while (!vin.ready);
    vsb.note_vertex(px, py, pz, nx, ny, nz, last);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'(int'($urandom_range(200000)) - 100000);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'(int'($urandom_range(131072)) - 65536);
      default: return $urandom_range(1) ? 32'h00010000 : 32'h0;
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      logic [15:0] nn [3];
      for (int k = 0; k < 3; k++)
        nn[k] = ($urandom_range(9) == 0) ? 16'h0 :
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'(int'($urandom_range(32768)) - 16384);
      send_vertex(rand_coord(), rand_coord(), rand_coord(), nn[0], nn[1], nn[2],
                  (i == count - 1) || ($urandom_range(15) == 0));
    end
  endtask

  task automatic drain();
    vin.valid <= 0;
    while (vsb.pending.size() != 0) @(posedge clk);
    repeat (SIM_LATENCY + 10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_matrix(input bit extreme);
    for (int r = 0; r < 6; r++)
      if (extreme)
        cfg_write(REG_ROW0_C01 + CFG_IDX_W'(r),
                  $urandom_range(1) ? {2{32'h7fffffff}} : {2{32'h80000000}});
      else
        cfg_write(REG_ROW0_C01 + CFG_IDX_W'(r), {rand_coef(), rand_coef()});
  endtask

  initial begin
    vin.valid = 0; vin.in_last = 0;
    vin.pos_x = 0; vin.pos_y = 0; vin.pos_z = 0;
    vin.nrm_x = 0; vin.nrm_y = 0; vin.nrm_z = 0;
    vcfg.valid = 0; vcfg.index = 0; vcfg.data = 0;
    vout.ready = 1;
    vsb.reset_regs();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: identity matrix, field extremes, zero normal
    send_vertex(32'sh7fffffff, 32'sh80000000, 0, 16'sh7fff, 16'sh8000, 0, 0);
    send_vertex(32'sh80000000, 32'sh7fffffff, -1, 16'sh4000, 0, 0, 0);
    send_vertex(0, 0, 0, 0, 0, 0, 0);
    send_vertex(32'h00018000, -32'sh00018000, 32'h00008000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_vertex(-1, 1, 32'h12345678, 16'sh0001, -16'sh0001, 16'sh0001, 1);
    drain();
    // saturating matrix and translation
    random_matrix(1);
    send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_vertex(0, 0, 0, 16'sh1234, -16'sh4321, 16'sh0fff, 1);
    drain();
    // zero matrix gives degenerate normals; passthrough with normals off
    for (int r = 0; r < 6; r++) cfg_write(REG_ROW0_C01 + CFG_IDX_W'(r), 64'h0);
    send_vertex(32'h00010000, 5, -5, 16'sh4000, 16'sh4000, 0, 0);
    drain();
    cfg_write(REG_TNORM, 64'h0);
    send_vertex(32'h00010000, 5, -5, 16'sh7fff, 16'sh8000, 16'sh1234, 1);
    drain();
    cfg_write(REG_TNORM, 64'hffff_fffe_ffff_ffff);

    // random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
        default: begin src_idle_pct = 27; sink_stall_pct = 27; end
      endcase
      random_matrix(0);
      cfg_write(REG_TNORM, 64'(ph % 3 != 2));
      send_random(48);
      drain();
    end
    sink_stall_pct = 0;

    $display("covered %0d vertices over several matrices, normals on and off,", sent);
    $display("with saturation, degenerate normals and sender/receiver stalls");
    if (errors == 0)
      $display("vertex_affine_transform verification clean");
    else
      $display("vertex_affine_transform verification failed");
    $finish;
  end
endmodule
